// ===== rtl/ifp_pkg.sv =====
// Package: phase codes, segment and status codes, frame layout constants.
package ifp_pkg;

    typedef enum logic [2:0] {
        PH_HDR   = 3'd0,
        PH_IDENT = 3'd1,
        PH_STRW  = 3'd2,
        PH_PAY   = 3'd3,
        PH_SKIP  = 3'd4
    } phase_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HDR_SUM  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BODY_SUM = 3'd3;
    localparam logic [2:0] ST_LEN      = 3'd4;
    localparam logic [2:0] ST_OVERSIZE = 3'd5;

    localparam logic [2:0] SEG_NAME  = 3'd0;
    localparam logic [2:0] SEG_DESC  = 3'd1;
    localparam logic [2:0] SEG_WR    = 3'd2;
    localparam logic [2:0] SEG_RD    = 3'd3;
    localparam logic [2:0] SEG_DATA  = 3'd4;

    localparam logic [2:0] CFG_REQUEST  = 3'd0;
    localparam logic [2:0] CFG_RESPONSE = 3'd1;
    localparam logic [2:0] CFG_IDENT    = 3'd2;
    localparam logic [2:0] CFG_STATE    = 3'd3;
    localparam logic [2:0] CFG_READ     = 3'd4;
    localparam logic [2:0] CFG_WRITE    = 3'd5;

    localparam logic [4:0] HDR_LEN   = 5'd20;
    localparam logic [4:0] IDENT_LEN = 5'd16;
    localparam logic [4:0] STRW_LEN  = 5'd15;

endpackage

// ===== rtl/iot_frame_parser_core.sv =====
// Top level: byte-stream frame parser with header/sub-header checks and payload forwarding.
//
// One word (byte) is accepted per cycle while in_ready is high. A 20-byte
// header is collected and its 64-bit additive sum checked; when type and
// assignment call for a body, a 16-byte identification or 15-byte
// state/read/write sub-header follows with its own sum and a length check
// against the declared body size. A summary word closes each sub-header, and
// each header without one; payload bytes are then forwarded tagged with their
// segment. After a checksum or length error the rest of the declared body,
// unless oversize, is dropped silently. Sums are built incrementally, one
// 64-bit add per byte. Results leave through a one-deep output register plus
// one skid register, so the input keeps flowing while a result waits.
// Configuration writes go through cfg_we/cfg_index/cfg_data and must be made
// while idle. BODY_BITS sets the width beyond which a body size is oversize.
module iot_frame_parser_core
    import ifp_pkg::*;
#(
    parameter int BODY_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        result_kind,
    output logic [7:0]  payload_byte,
    output logic [2:0]  segment,
    output logic [2:0]  status,
    output logic [7:0]  version,
    output logic [7:0]  msg_type,
    output logic [7:0]  assignment,
    output logic [7:0]  hdr_flags,
    output logic [31:0] body_size,
    output logic [15:0] body_key,
    output logic [7:0]  body_flags
);

    typedef struct packed {
        logic        kind;
        logic [7:0]  pbyte;
        logic [2:0]  seg;
        logic [2:0]  st;
        logic [7:0]  ver;
        logic [7:0]  typ;
        logic [7:0]  asg;
        logic [7:0]  flg;
        logic [31:0] size;
        logic [15:0] key;
        logic [7:0]  bflg;
    } res_t;

    // configuration
    logic [7:0] c_req_reg, c_rsp_reg, c_id_reg, c_st_reg, c_rd_reg, c_wr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_req_reg <= 8'd1;
            c_rsp_reg <= 8'd2;
            c_id_reg  <= 8'd1;
            c_st_reg  <= 8'd2;
            c_rd_reg  <= 8'd3;
            c_wr_reg  <= 8'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REQUEST:  c_req_reg <= cfg_data;
                CFG_RESPONSE: c_rsp_reg <= cfg_data;
                CFG_IDENT:    c_id_reg  <= cfg_data;
                CFG_STATE:    c_st_reg  <= cfg_data;
                CFG_READ:     c_rd_reg  <= cfg_data;
                CFG_WRITE:    c_wr_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // parser state
    phase_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] hdr_reg, hdr_next;        // version, type, assignment, flags
    logic        is_id_reg, is_id_next;
    logic        subv_reg, subv_next;
    logic [63:0] body_reg, body_next;      // declared / remaining body
    logic [63:0] rsum_reg, rsum_next;      // running sum of covered fields
    logic [63:0] xsum_reg, xsum_next;      // received checksum
    logic [63:0] sub_reg, sub_next;        // sub-header bytes 0..7
    logic [31:0] rem_reg, rem_next;
    logic [2:0]  cseg_reg, cseg_next;

    // output register and skid
    res_t out_reg, out_next, skid_reg, skid_next;
    logic out_v_reg, out_v_next, skid_v_reg, skid_v_next;

    assign in_ready = !skid_v_reg;
    logic acc;
    assign acc = in_valid && in_ready;

    logic [7:0] b;
    assign b = byte_in;

    // helpers on the sub-header as it stands after this byte
    function automatic logic [7:0] sb(input logic [63:0] s, input int i);
        sb = s[i*8 +: 8];
    endfunction

    function automatic logic [31:0] seg_len(input logic [63:0] s, input logic id,
                                            input logic [2:0] k);
        seg_len = 32'd0;
        if (id)
        begin
            case (k)
                SEG_NAME: seg_len = {24'd0, sb(s, 2)};
                SEG_DESC: seg_len = {16'd0, sb(s, 3), sb(s, 4)};
                SEG_WR:   seg_len = {24'd0, sb(s, 5)};
                SEG_RD:   seg_len = {24'd0, sb(s, 6)};
                default:  seg_len = 32'd0;
            endcase
        end
        else
        begin
            case (k)
                SEG_NAME: seg_len = {24'd0, sb(s, 0)};
                SEG_DATA: seg_len = {sb(s, 6), sb(s, 5), sb(s, 4), sb(s, 3)};
                default:  seg_len = 32'd0;
            endcase
        end
    endfunction

    // first nonempty segment at or after start; found=0 when none
    typedef struct packed {
        logic        found;
        logic [2:0]  seg;
        logic [31:0] len;
    } adv_t;

    function automatic adv_t advance(input logic [63:0] s, input logic id,
                                     input logic [3:0] start);
        adv_t r;
        logic [31:0] l;
        r = '0;
        for (int k = 4; k >= 0; k--)
        begin
            l = seg_len(s, id, 3'(k));
            if (k >= int'(start) && l != 32'd0)
            begin
                r.found = 1'b1;
                r.seg   = 3'(k);
                r.len   = l;
            end
        end
        return r;
    endfunction

    logic oversize;
    logic body_req;
    logic [7:0] h_typ, h_asg;

    always_comb
    begin
        res_t r;
        logic emit;
        logic [63:0] sum_b;
        logic [63:0] tot;
        logic [4:0] p;
        logic [4:0] slen;
        logic [2:0] st;
        adv_t a;

        phase_next = phase_reg;
        pos_next   = pos_reg;
        hdr_next   = hdr_reg;
        is_id_next = is_id_reg;
        subv_next  = subv_reg;
        body_next  = body_reg;
        rsum_next  = rsum_reg;
        xsum_next  = xsum_reg;
        sub_next   = sub_reg;
        rem_next   = rem_reg;
        cseg_next  = cseg_reg;
        emit = 1'b0;
        r = '0;
        sum_b = 64'd0;
        tot = 64'd0;
        p = pos_reg;
        slen = STRW_LEN;
        st = ST_OK;
        a = '0;
        h_typ = hdr_reg[15:8];
        h_asg = hdr_reg[23:16];
        oversize = 1'b0;
        body_req = 1'b0;

        if (acc)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    if (p >= HDR_LEN) p = 5'd0;
                    if (p == 5'd0)
                    begin
                        hdr_next  = '0;
                        body_next = '0;
                        xsum_next = '0;
                        sub_next  = '0;
                        rsum_next = '0;
                        is_id_next = 1'b0;
                        subv_next  = 1'b0;
                    end
                    if (p < 5'd4)
                    begin
                        hdr_next[p[1:0]*8 +: 8] = b;
                        rsum_next = rsum_next + {56'd0, b};
                    end
                    else if (p < 5'd12)
                    begin
                        body_next[3'(p - 5'd4)*8 +: 8] = b;
                        rsum_next = rsum_next + ({56'd0, b} << (6'(p - 5'd4) * 8));
                    end
                    else
                        xsum_next[3'(p - 5'd12)*8 +: 8] = b;
                    pos_next = p + 5'd1;
                    if (p + 5'd1 == HDR_LEN)
                    begin
                        pos_next = 5'd0;
                        phase_next = PH_HDR;
                        emit = 1'b1;
                        h_typ = hdr_next[15:8];
                        h_asg = hdr_next[23:16];
                        if (BODY_BITS < 64)
                            oversize = (body_next >> BODY_BITS) != 64'd0;
                        if (h_typ == c_rsp_reg)
                            body_req = h_asg == c_id_reg || h_asg == c_st_reg
                                       || h_asg == c_rd_reg || h_asg == c_wr_reg;
                        else if (h_typ == c_req_reg)
                            body_req = h_asg == c_st_reg || h_asg == c_rd_reg
                                       || h_asg == c_wr_reg;
                        if (rsum_next != xsum_next)
                        begin
                            st = ST_HDR_SUM;
                            if (!oversize && body_next != 64'd0) phase_next = PH_SKIP;
                        end
                        else if (oversize) st = ST_OVERSIZE;
                        else if (!body_req) st = ST_OK;
                        else if (body_next == 64'd0) st = ST_EMPTY;
                        else
                        begin
                            emit = 1'b0;
                            if (h_asg == c_id_reg)
                            begin
                                is_id_next = 1'b1;
                                phase_next = PH_IDENT;
                            end
                            else
                                phase_next = PH_STRW;
                            xsum_next = '0;
                            sub_next  = '0;
                            rsum_next = '0;
                        end
                    end
                end
                PH_IDENT, PH_STRW:
                begin
                    slen = (phase_reg == PH_IDENT) ? IDENT_LEN : STRW_LEN;
                    if (p >= slen) p = 5'd0;
                    if (p < slen - 5'd8)
                    begin
                        sub_next[3'(p)*8 +: 8] = b;
                        // add byte at its weight in the covered sum
                        if (phase_reg == PH_IDENT)
                            sum_b = (p == 5'd0 || p == 5'd3) ? {48'd0, b, 8'd0}
                                                              : {56'd0, b};
                        else
                            case (p)
                                5'd3:    sum_b = {56'd0, b};
                                5'd4:    sum_b = {48'd0, b, 8'd0};
                                5'd5:    sum_b = {40'd0, b, 16'd0};
                                5'd6:    sum_b = {32'd0, b, 24'd0};
                                default: sum_b = {56'd0, b};
                            endcase
                        rsum_next = rsum_reg + sum_b;
                    end
                    else
                        xsum_next[3'(p - (slen - 5'd8))*8 +: 8] = b;
                    pos_next = p + 5'd1;
                    if (p + 5'd1 == slen)
                    begin
                        pos_next = 5'd0;
                        subv_next = 1'b1;
                        emit = 1'b1;
                        tot = {59'd0, slen};
                        for (int k = 0; k <= 4; k++)
                            tot = tot + {32'd0, seg_len(sub_next, is_id_reg, 3'(k))};
                        if (rsum_next != xsum_next) st = ST_BODY_SUM;
                        else if (tot != body_reg) st = ST_LEN;
                        else st = ST_OK;
                        if (st != ST_OK)
                        begin
                            body_next = (body_reg > {59'd0, slen})
                                        ? body_reg - {59'd0, slen} : 64'd0;
                            phase_next = (body_next != 64'd0) ? PH_SKIP : PH_HDR;
                        end
                        else
                        begin
                            a = advance(sub_next, is_id_reg, 4'd0);
                            if (a.found)
                            begin
                                cseg_next = a.seg;
                                rem_next = a.len;
                                phase_next = PH_PAY;
                            end
                            else
                                phase_next = PH_HDR;
                        end
                    end
                end
                PH_PAY:
                begin
                    emit = 1'b1;
                    r.pbyte = b;
                    r.seg = cseg_reg;
                    rem_next = (rem_reg > 32'd0) ? rem_reg - 32'd1 : 32'd0;
                    if (rem_next == 32'd0)
                    begin
                        a = advance(sub_reg, is_id_reg, {1'b0, cseg_reg} + 4'd1);
                        if (a.found)
                        begin
                            cseg_next = a.seg;
                            rem_next = a.len;
                        end
                        else
                        begin
                            phase_next = PH_HDR;
                            pos_next = 5'd0;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (body_reg > 64'd0) body_next = body_reg - 64'd1;
                    if (body_next == 64'd0)
                    begin
                        phase_next = PH_HDR;
                        pos_next = 5'd0;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR;
                    pos_next = 5'd0;
                end
            endcase

            // summary fields
            if (emit && phase_reg != PH_PAY)
            begin
                r.kind = 1'b1;
                r.st   = st;
                r.ver  = hdr_next[7:0];
                r.typ  = hdr_next[15:8];
                r.asg  = hdr_next[23:16];
                r.flg  = hdr_next[31:24];
                r.size = body_reg[31:0];
                if (phase_reg == PH_HDR) r.size = body_next[31:0];
                if (subv_next)
                begin
                    r.key  = is_id_reg ? {sb(sub_next, 0), sb(sub_next, 1)}
                                       : {8'd0, sb(sub_next, 1)};
                    r.bflg = is_id_reg ? sb(sub_next, 7) : sb(sub_next, 2);
                end
            end
        end

        out_next   = out_reg;
        out_v_next = out_v_reg;
        skid_next  = skid_reg;
        skid_v_next = skid_v_reg;
        if (out_v_reg && result_ready)
        begin
            out_v_next = skid_v_reg;
            out_next = skid_reg;
            skid_v_next = 1'b0;
        end
        if (emit)
        begin
            if (!out_v_next)
            begin
                out_next = r;
                out_v_next = 1'b1;
            end
            else
            begin
                skid_next = r;
                skid_v_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR;
            pos_reg    <= '0;
            hdr_reg    <= '0;
            is_id_reg  <= 1'b0;
            subv_reg   <= 1'b0;
            body_reg   <= '0;
            rsum_reg   <= '0;
            xsum_reg   <= '0;
            sub_reg    <= '0;
            rem_reg    <= '0;
            cseg_reg   <= '0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            hdr_reg    <= hdr_next;
            is_id_reg  <= is_id_next;
            subv_reg   <= subv_next;
            body_reg   <= body_next;
            rsum_reg   <= rsum_next;
            xsum_reg   <= xsum_next;
            sub_reg    <= sub_next;
            rem_reg    <= rem_next;
            cseg_reg   <= cseg_next;
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_valid = out_v_reg;
    assign result_kind  = out_reg.kind;
    assign payload_byte = out_reg.pbyte;
    assign segment      = out_reg.seg;
    assign status       = out_reg.st;
    assign version      = out_reg.ver;
    assign msg_type     = out_reg.typ;
    assign assignment   = out_reg.asg;
    assign hdr_flags    = out_reg.flg;
    assign body_size    = out_reg.size;
    assign body_key     = out_reg.key;
    assign body_flags   = out_reg.bflg;

endmodule
